### sv/mfps_pkg.sv
// shared constants and types for the minimum falling path sum unit
// no dependencies; compile first
package mfps_pkg;

   // fixed field widths
   localparam int CELL_W  = 16;
   localparam int OUT_W   = 22;
   localparam int SIDE_W  = 7;
   localparam int STORE_W = 24;

   // running minimum start value, largest positive 24-bit value
   localparam int RUN_MIN_RESET = 8388607;

   // per-cell position flags carried from the sequencer to the path unit
   typedef struct packed {
      logic first_row;
      logic has_left;
      logic last_col;
      logic last_row;
   } cell_flags_type;

endpackage

### sv/mfps_req_if.sv
// request channel carrying one matrix cell cost per transfer
// depends on mfps_pkg
interface mfps_req_if;
   import mfps_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [CELL_W-1:0] cell_cost;

   modport source (output valid, output cell_cost, input ready);
   modport sink (input valid, input cell_cost, output ready);
endinterface

### sv/mfps_rsp_if.sv
// response channel carrying one minimum path sum per transfer
// depends on mfps_pkg
interface mfps_rsp_if;
   import mfps_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] min_path_sum;

   modport source (output valid, output min_path_sum, input ready);
   modport sink (input valid, input min_path_sum, output ready);
endinterface

### sv/min_falling_path_sum_unit.sv
// Minimum falling path sum over a square matrix streamed one cell per transfer in
// row-major order; the side length comes from csr_wr_data and a write restarts the
// matrix. The unit takes one cell every clock unless the input stalls: a cell is
// read out of the row store one entry ahead at its transfer and finished in the
// compute stage, where its path cost is written back, so throughput is set by the
// single read and single write port of the row store; the last cell's result is
// registered. Input stalls only when one matrix ends while the previous result
// still waits on rsp_if.ready. The row store needs no clearing after reset.
// depends on mfps_pkg, mfps_req_if, mfps_rsp_if, mfps_seq, mfps_row_store,
// mfps_path_unit
module min_falling_path_sum_unit #(
   parameter int MAX_SIDE = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   mfps_req_if.sink                    req_if,
   mfps_rsp_if.source                  rsp_if,
   input  logic                        csr_wr_en,
   input  logic [mfps_pkg::SIDE_W-1:0] csr_wr_data
);
   import mfps_pkg::*;

   localparam int COL_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int PATH_W = (CELL_W + COL_W > STORE_W) ? CELL_W + COL_W : STORE_W;

   logic                     accept, stall;
   logic [COL_W-1:0]         rd_addr;
   logic                     b_valid;
   cell_flags_type           b_flags;
   logic [COL_W-1:0]         b_col;
   logic signed [CELL_W-1:0] b_cost;
   logic signed [PATH_W-1:0] win_left, win_above, win_right;
   logic                     wr_en;
   logic [COL_W-1:0]         wr_addr;
   logic signed [PATH_W-1:0] wr_data;

   // input transfer
   assign req_if.ready = !reset && !stall;
   assign accept       = req_if.valid && req_if.ready;

   mfps_seq #(
      .MAX_SIDE (MAX_SIDE),
      .COL_W    (COL_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .stall       (stall),
      .cell_cost   (req_if.cell_cost),
      .rd_addr     (rd_addr),
      .b_valid     (b_valid),
      .b_flags     (b_flags),
      .b_col       (b_col),
      .b_cost      (b_cost)
   );

   mfps_row_store #(
      .DEPTH  (MAX_SIDE),
      .COL_W  (COL_W),
      .PATH_W (PATH_W)
   ) u_row_store (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr   (rd_addr),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .win_left  (win_left),
      .win_above (win_above),
      .win_right (win_right)
   );

   mfps_path_unit #(
      .COL_W  (COL_W),
      .PATH_W (PATH_W)
   ) u_path_unit (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .b_valid   (b_valid),
      .b_flags   (b_flags),
      .b_col     (b_col),
      .b_cost    (b_cost),
      .win_left  (win_left),
      .win_above (win_above),
      .win_right (win_right),
      .rsp_ready (rsp_if.ready),
      .stall     (stall),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rsp_valid (rsp_if.valid),
      .rsp_data  (rsp_if.min_path_sum)
   );
endmodule

### sv/mfps_seq.sv
// side length register, row and column counters, and the compute stage registers
// depends on mfps_pkg
module mfps_seq #(
   parameter int MAX_SIDE = 64,
   parameter int COL_W    = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [mfps_pkg::SIDE_W-1:0]      csr_wr_data,
   input  logic                             accept,
   input  logic                             stall,
   input  logic signed [mfps_pkg::CELL_W-1:0] cell_cost,
   output logic [COL_W-1:0]                 rd_addr,
   output logic                             b_valid,
   output mfps_pkg::cell_flags_type         b_flags,
   output logic [COL_W-1:0]                 b_col,
   output logic signed [mfps_pkg::CELL_W-1:0] b_cost
);
   import mfps_pkg::*;

   localparam int N_W   = COL_W + 1;
   localparam int CMP_W = (N_W > SIDE_W) ? N_W : SIDE_W;

   logic [SIDE_W-1:0]        side_ff;
   logic [COL_W-1:0]         col_ff, col_in;
   logic [COL_W-1:0]         row_ff, row_in;
   logic                     b_valid_ff;
   cell_flags_type           b_flags_ff;
   logic [COL_W-1:0]         b_col_ff;
   logic signed [CELL_W-1:0] b_cost_ff;

   logic [CMP_W-1:0] side_ext, n_cmp;
   logic [N_W-1:0]   n_eff, col_nx, row_nx;
   logic             last_col, last_row;
   cell_flags_type   flags;

   // effective side length: zero means one, clipped at the store depth
   always_comb begin
      side_ext = CMP_W'(side_ff);
      if (side_ext == '0) begin
         n_cmp = CMP_W'(1);
      end else if (side_ext > CMP_W'(MAX_SIDE)) begin
         n_cmp = CMP_W'(MAX_SIDE);
      end else begin
         n_cmp = side_ext;
      end
      n_eff = n_cmp[N_W-1:0];
   end

   // position of the cell at the input
   always_comb begin
      col_nx   = {1'b0, col_ff} + N_W'(1);
      row_nx   = {1'b0, row_ff} + N_W'(1);
      last_col = (col_nx == n_eff);
      last_row = (row_nx == n_eff);
      flags.first_row = (row_ff == '0);
      flags.has_left  = (col_ff != '0);
      flags.last_col  = last_col;
      flags.last_row  = last_row;
      // fetch the up-right entry, or entry zero for the next row
      rd_addr = last_col ? '0 : col_nx[COL_W-1:0];
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_nx[COL_W-1:0];
      end else begin
         col_in = col_nx[COL_W-1:0];
         row_in = row_ff;
      end
   end

   // side register and counters; a register write restarts the matrix
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_W'(1);
         col_ff  <= '0;
         row_ff  <= '0;
      end else if (csr_wr_en) begin
         side_ff <= csr_wr_data;
         col_ff  <= '0;
         row_ff  <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // compute stage valid, held while the finished sum cannot leave
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (!stall) begin
         b_valid_ff <= accept;
      end
   end

   // compute stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         b_flags_ff <= flags;
         b_col_ff   <= col_ff;
         b_cost_ff  <= cell_cost;
      end
   end

   assign b_valid = b_valid_ff;
   assign b_flags = b_flags_ff;
   assign b_col   = b_col_ff;
   assign b_cost  = b_cost_ff;
endmodule

### sv/mfps_row_store.sv
// row store of path costs: one write port, one registered read port with
// same-cycle forwarding, and a three-entry window of previous-row costs
module mfps_row_store #(
   parameter int DEPTH  = 64,
   parameter int COL_W  = 6,
   parameter int PATH_W = 24
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [COL_W-1:0]         rd_addr,
   input  logic                     wr_en,
   input  logic [COL_W-1:0]         wr_addr,
   input  logic signed [PATH_W-1:0] wr_data,
   output logic signed [PATH_W-1:0] win_left,
   output logic signed [PATH_W-1:0] win_above,
   output logic signed [PATH_W-1:0] win_right
);
   logic signed [PATH_W-1:0] row_mem [DEPTH];
   logic signed [PATH_W-1:0] rd_ff;
   logic signed [PATH_W-1:0] above_ff;
   logic signed [PATH_W-1:0] left_ff;

   // write back of the computed path cost
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
   end

   // read one entry ahead and slide the window on every input transfer
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_ff <= wr_data;
         end else begin
            rd_ff <= row_mem[rd_addr];
         end
         above_ff <= rd_ff;
         left_ff  <= above_ff;
      end
   end

   assign win_left  = left_ff;
   assign win_above = above_ff;
   assign win_right = rd_ff;
endmodule

### sv/mfps_path_unit.sv
// path cost add, running minimum over the final row, and the result register
// depends on mfps_pkg
module mfps_path_unit #(
   parameter int COL_W  = 6,
   parameter int PATH_W = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic                               b_valid,
   input  mfps_pkg::cell_flags_type           b_flags,
   input  logic [COL_W-1:0]                   b_col,
   input  logic signed [mfps_pkg::CELL_W-1:0] b_cost,
   input  logic signed [PATH_W-1:0]           win_left,
   input  logic signed [PATH_W-1:0]           win_above,
   input  logic signed [PATH_W-1:0]           win_right,
   input  logic                               rsp_ready,
   output logic                               stall,
   output logic                               wr_en,
   output logic [COL_W-1:0]                   wr_addr,
   output logic signed [PATH_W-1:0]           wr_data,
   output logic                               rsp_valid,
   output logic signed [mfps_pkg::OUT_W-1:0]  rsp_data
);
   import mfps_pkg::*;

   localparam logic signed [PATH_W-1:0] RUN_MIN_INIT = PATH_W'(RUN_MIN_RESET);

   logic signed [PATH_W-1:0] run_min_ff;
   logic                     rsp_valid_ff;
   logic signed [OUT_W-1:0]  rsp_data_ff;

   logic signed [PATH_W-1:0] cost_ext, best, path, run_cand;
   logic                     last_cell, fire;

   // smallest of up-left, up and up-right plus the cell cost; the cell cost alone on the first row
   always_comb begin
      cost_ext = PATH_W'(b_cost);
      best     = win_above;
      if (b_flags.has_left && (win_left < best)) begin
         best = win_left;
      end
      if (!b_flags.last_col && (win_right < best)) begin
         best = win_right;
      end
      path     = b_flags.first_row ? cost_ext : best + cost_ext;
      run_cand = (path < run_min_ff) ? path : run_min_ff;
   end

   // hold the stage only when a matrix ends and the result slot is blocked
   always_comb begin
      last_cell = b_flags.last_row && b_flags.last_col;
      stall     = b_valid && last_cell && rsp_valid_ff && !rsp_ready;
      fire      = b_valid && !stall;
   end

   assign wr_en   = fire;
   assign wr_addr = b_col;
   assign wr_data = path;

   // running minimum over the final row
   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         run_min_ff <= RUN_MIN_INIT;
      end else if (fire && b_flags.last_row) begin
         run_min_ff <= b_flags.last_col ? RUN_MIN_INIT : run_cand;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && last_cell) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && last_cell) begin
         rsp_data_ff <= run_cand[OUT_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

### sv/mfps_checker.sv
// port-level checks for min_falling_path_sum_unit and the bind that attaches them
// depends on mfps_pkg and min_falling_path_sum_unit
module mfps_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [mfps_pkg::OUT_W-1:0] min_path_sum
);
   // a waiting result stays offered
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a waiting result keeps its value
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(min_path_sum))
      else $error("result changed while stalled");

   // input backpressure only comes from a blocked result
   a_ready_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled with no blocked result");

   // a fresh result follows a cell transfer through the compute stage and result register
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a preceding cell transfer");

   // reset empties the result register
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");
endmodule

bind min_falling_path_sum_unit mfps_checker u_mfps_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .min_path_sum (rsp_if.min_path_sum)
);
